// ----- sv/bma_pkg.sv -----
// Shared types and codes for the block map allocator.
package bma_pkg;

    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE  = 2'd1;
    localparam logic [1:0] FN_USAGE = 2'd2;
    localparam logic [1:0] FN_INIT  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_FAIL      = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic        pool;
        logic [19:0] size_bytes;
        logic [19:0] offset_bytes;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] alloc_offset;
        logic [6:0]  usage_percent;
    } t_res;

endpackage

// ----- sv/block_map_allocator_top.sv -----
// Top level: two-pool block map allocator over map RAMs with constant dividers.
// The strobe rises as busy falls; for a free that is not ready or out of range it rises
// while busy stays low.
// Throughput: one request at a time, bounded by the one-entry-per-cycle map port.
// Reset: synchronous; a clearing pass over both maps keeps busy high;
// the receiver cannot stall results.
module block_map_allocator_top #(
    parameter int POOL0_BLOCKS      = 4096,
    parameter int POOL1_BLOCKS      = 8192,
    parameter int POOL0_BLOCK_BYTES = 32,
    parameter int POOL1_BLOCK_BYTES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          start,
    input  bma_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output bma_pkg::t_res o_res
);
    import bma_pkg::*;

    localparam int MAXB = (POOL0_BLOCKS > POOL1_BLOCKS) ? POOL0_BLOCKS : POOL1_BLOCKS;
    localparam int CW   = $clog2(MAXB + 1);
    localparam int AW0  = $clog2(POOL0_BLOCKS);
    localparam int AW1  = $clog2(POOL1_BLOCKS);
    localparam int DW0  = $clog2(POOL0_BLOCKS + 1);
    localparam int DW1  = $clog2(POOL1_BLOCKS + 1);
    localparam int BNW  = 21;
    localparam int UNW  = CW + 7;
    localparam int NUMW = (BNW > UNW) ? BNW : UNW;
    localparam logic [31:0] LIM0 = 32'(POOL0_BLOCKS * POOL0_BLOCK_BYTES);
    localparam logic [31:0] LIM1 = 32'(POOL1_BLOCKS * POOL1_BLOCK_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FRD  = 3'd3;
    localparam logic [2:0] S_FRD2 = 3'd4;
    localparam logic [2:0] S_FILL = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [1:0]      r_func, n_func;
    logic            r_p, n_p;
    logic [1:0]      r_ready, n_ready;
    logic            r_epf, n_epf;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_vld, n_vld;
    logic [CW-1:0]   r_paddr, n_paddr;
    logic [CW-1:0]   r_run, n_run;
    logic [CW-1:0]   r_need, n_need;
    logic [CW-1:0]   r_used, n_used;
    logic [CW-1:0]   r_waddr, n_waddr;
    logic [CW-1:0]   r_wend, n_wend;
    logic [CW-1:0]   r_wval, n_wval;
    logic            r_wall, n_wall;
    logic [1:0]      r_stat, n_stat;
    logic [17:0]     r_aoff, n_aoff;
    logic [6:0]      r_usage, n_usage;
    logic            r_strobe, n_strobe;
    logic [NUMW-1:0] r_num, n_num;

    logic           sel_p, eff_p;
    logic [CW-1:0]  blocks_p;
    logic [12:0]    bbytes_p;
    logic [31:0]    lim_p;
    logic [CW-1:0]  rd_addr, rd_data, run_inc, used_inc;
    logic [DW0-1:0] rd0;
    logic [DW1-1:0] rd1;
    logic           we0, we1, fill_on;
    logic [BNW-1:0] bq0, bq1, need;
    logic [UNW-1:0] uq0, uq1, uquot;
    logic [CW:0]    fend;
    logic [CW+12:0] prod;

    assign eff_p    = i_req.pool & ~r_epf;
    assign sel_p    = (r_state == S_IDLE) ? eff_p : r_p;
    assign blocks_p = sel_p ? CW'(POOL1_BLOCKS) : CW'(POOL0_BLOCKS);
    assign bbytes_p = sel_p ? 13'(POOL1_BLOCK_BYTES) : 13'(POOL0_BLOCK_BYTES);
    assign lim_p    = sel_p ? LIM1 : LIM0;
    assign rd_data  = r_p ? CW'(rd1) : CW'(rd0);
    assign rd_addr  = (r_state == S_SCAN) ? r_cnt - 1'b1 : r_waddr;
    assign run_inc  = (rd_data == '0) ? r_run + 1'b1 : '0;
    assign used_inc = r_used + CW'(rd_data != '0);
    assign need     = r_p ? bq1 : bq0;
    assign uquot    = r_p ? uq1 : uq0;
    assign fend     = (CW + 1)'(r_waddr) + (CW + 1)'(rd_data);
    assign prod     = (CW + 13)'(r_paddr) * (CW + 13)'(bbytes_p);

    assign fill_on = (r_state == S_FILL) && (r_waddr < r_wend);
    assign we0 = fill_on && (r_wall || !r_p) && (r_waddr < CW'(POOL0_BLOCKS));
    assign we1 = fill_on && (r_wall || r_p) && (r_waddr < CW'(POOL1_BLOCKS));

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_p       = r_p;
        n_ready   = r_ready;
        n_epf     = i_cfg_we ? i_cfg_wdata : r_epf;
        n_cnt     = r_cnt;
        n_vld     = r_vld;
        n_paddr   = r_paddr;
        n_run     = r_run;
        n_need    = r_need;
        n_used    = r_used;
        n_waddr   = r_waddr;
        n_wend    = r_wend;
        n_wval    = r_wval;
        n_wall    = r_wall;
        n_stat    = r_stat;
        n_aoff    = r_aoff;
        n_usage   = r_usage;
        n_strobe  = 1'b0;
        n_num     = r_num;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func  = i_req.func;
                    n_p     = eff_p;
                    n_stat  = ST_OK;
                    n_aoff  = '0;
                    n_usage = '0;
                    n_wall  = 1'b0;
                    unique case (i_req.func)
                        FN_ALLOC: begin
                            n_ready[eff_p] = 1'b1;
                            n_num   = NUMW'(i_req.size_bytes) + NUMW'(bbytes_p - 13'd1);
                            n_state = S_DIV;
                        end
                        FN_FREE: begin
                            if (!r_ready[eff_p]) begin
                                n_ready[eff_p] = 1'b1;
                                n_stat         = ST_NOT_READY;
                                n_strobe       = 1'b1;
                            end else if (32'(i_req.offset_bytes) >= lim_p) begin
                                n_stat   = ST_RANGE;
                                n_strobe = 1'b1;
                            end else begin
                                n_num   = NUMW'(i_req.offset_bytes);
                                n_state = S_DIV;
                            end
                        end
                        FN_USAGE: begin
                            n_cnt   = blocks_p;
                            n_vld   = 1'b0;
                            n_used  = '0;
                            n_state = S_SCAN;
                        end
                        FN_INIT: begin
                            n_ready[eff_p] = 1'b1;
                            n_waddr        = '0;
                            n_wend         = blocks_p;
                            n_wval         = '0;
                            n_state        = S_FILL;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                priority if (r_func == FN_ALLOC) begin
                    if (need == '0 || need > BNW'(blocks_p)) begin
                        n_stat   = ST_FAIL;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_need  = need[CW-1:0];
                        n_cnt   = blocks_p;
                        n_vld   = 1'b0;
                        n_run   = '0;
                        n_state = S_SCAN;
                    end
                end else if (r_func == FN_FREE) begin
                    n_waddr = need[CW-1:0];
                    n_state = S_FRD;
                end else begin
                    n_usage  = uquot[6:0];
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN: begin
                n_vld = (r_cnt != '0);
                if (r_cnt != '0) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_paddr = r_cnt - 1'b1;
                end
                if (r_vld) begin
                    if (r_func == FN_ALLOC) begin
                        n_run = run_inc;
                        if (run_inc == r_need) begin
                            n_waddr = r_paddr;
                            n_wend  = r_paddr + r_need;
                            n_wval  = r_need;
                            n_aoff  = prod[17:0];
                            n_state = S_FILL;
                        end else if (r_paddr == '0) begin
                            n_stat   = ST_FAIL;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end else begin
                        n_used = used_inc;
                        if (r_paddr == '0) begin
                            n_num   = NUMW'(used_inc) * NUMW'(7'd100);
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_FRD: begin
                n_state = S_FRD2;
            end
            S_FRD2: begin
                n_wend  = (fend > (CW + 1)'(blocks_p)) ? blocks_p : fend[CW-1:0];
                n_wval  = '0;
                n_state = S_FILL;
            end
            S_FILL: begin
                if (fill_on) begin
                    n_waddr = r_waddr + 1'b1;
                end else begin
                    n_strobe = !r_wall;
                    n_wall   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_waddr  <= '0;
            r_wend   <= CW'(MAXB);
            r_wval   <= '0;
            r_wall   <= 1'b1;
            r_ready  <= '0;
            r_epf    <= 1'b0;
            r_strobe <= 1'b0;
            r_vld    <= 1'b0;
            r_num    <= '0;
        end else begin
            r_state  <= n_state;
            r_waddr  <= n_waddr;
            r_wend   <= n_wend;
            r_wval   <= n_wval;
            r_wall   <= n_wall;
            r_ready  <= n_ready;
            r_epf    <= n_epf;
            r_strobe <= n_strobe;
            r_vld    <= n_vld;
            r_num    <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_p     <= n_p;
        r_cnt   <= n_cnt;
        r_paddr <= n_paddr;
        r_run   <= n_run;
        r_need  <= n_need;
        r_used  <= n_used;
        r_stat  <= n_stat;
        r_aoff  <= n_aoff;
        r_usage <= n_usage;
    end

    bma_ram #(.W(DW0), .D(POOL0_BLOCKS)) u_map0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (r_waddr[AW0-1:0]),
        .i_wdata (r_wval[DW0-1:0]),
        .i_raddr (rd_addr[AW0-1:0]),
        .o_rdata (rd0)
    );

    bma_ram #(.W(DW1), .D(POOL1_BLOCKS)) u_map1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_waddr[AW1-1:0]),
        .i_wdata (r_wval[DW1-1:0]),
        .i_raddr (rd_addr[AW1-1:0]),
        .o_rdata (rd1)
    );

    bma_div #(.NW(BNW), .D(POOL0_BLOCK_BYTES)) u_bdiv0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r_num[BNW-1:0]),
        .o_quot  (bq0)
    );

    bma_div #(.NW(BNW), .D(POOL1_BLOCK_BYTES)) u_bdiv1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r_num[BNW-1:0]),
        .o_quot  (bq1)
    );

    bma_div #(.NW(UNW), .D(POOL0_BLOCKS)) u_udiv0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r_num[UNW-1:0]),
        .o_quot  (uq0)
    );

    bma_div #(.NW(UNW), .D(POOL1_BLOCKS)) u_udiv1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r_num[UNW-1:0]),
        .o_quot  (uq1)
    );

    assign busy                = (r_state != S_IDLE);
    assign o_strobe            = r_strobe;
    assign o_res.status        = r_stat;
    assign o_res.alloc_offset  = r_aoff;
    assign o_res.usage_percent = r_usage;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.func != FN_FREE) |=> busy)
        else $error("request accepted without going busy");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE)) else $error("result while still working");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && !r_wall) |->
        (r_wend <= (r_p ? CW'(POOL1_BLOCKS) : CW'(POOL0_BLOCKS))))
        else $error("fill past end of map");
    a_usage_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_usage <= 7'd100)) else $error("usage above full");
endmodule

// ----- sv/bma_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bma_ram #(
    parameter int W = 16,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/bma_div.sv -----
// Division by a constant through reciprocal multiplication.
module bma_div #(
    parameter int NW = 21,
    parameter int D  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [NW-1:0] i_num,
    output logic [NW-1:0] o_quot
);
    localparam int L  = $clog2(D);
    localparam int S  = NW + L;
    localparam int MW = NW + 2;
    localparam logic [63:0] M64 = ((64'd1 << S) + 64'(D - 1)) / 64'(D);
    localparam logic [MW-1:0] M = M64[MW-1:0];

    logic [NW+MW-1:0] prod;

    assign prod   = (NW + MW)'(i_num) * (NW + MW)'(M);
    assign o_quot = NW'(prod >> S);

    a_quot_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (64'(o_quot) * 64'(D) <= 64'(i_num))) else $error("quotient too large");
    a_quot_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((64'(o_quot) + 64'd1) * 64'(D) > 64'(i_num))) else $error("quotient too small");
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_quot <= i_num)) else $error("quotient above dividend");
endmodule

// ----- tb/block_map_allocator_top_tb.sv -----
// Testbench for the block map allocator: random and directed requests checked against a model.
module block_map_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bma_pkg::*;

    localparam int P0_BLOCKS = 4096;
    localparam int P1_BLOCKS = 8192;
    localparam int BLK_BYTES = 32;
    localparam int STALL_LIMIT = 100000;

    class alloc_scoreboard;
        logic [13:0] map0 [P0_BLOCKS];
        logic [13:0] map1 [P1_BLOCKS];
        bit ready [2];
        bit ext_failed;
        t_res pending [$];
        int errors;

        function void clear_pool(int p);
            if (p == 0) foreach (map0[i]) map0[i] = '0;
            else foreach (map1[i]) map1[i] = '0;
            ready[p] = 1'b1;
        endfunction

        function logic [13:0] rd(int p, int i);
            return (p == 0) ? map0[i] : map1[i];
        endfunction

        function void wr(int p, int i, logic [13:0] v);
            if (p == 0) map0[i] = v;
            else map1[i] = v;
        endfunction

        function void reset_state();
            foreach (map0[i]) map0[i] = '0;
            foreach (map1[i]) map1[i] = '0;
            ready[0] = 0;
            ready[1] = 0;
            ext_failed = 0;
            errors = 0;
        endfunction

        function void note_request(t_req r);
            t_res res;
            int p, blocks, need, run, idx, stop, used;
            bit found;
            res = '0;
            p = ext_failed ? 0 : r.pool;
            blocks = (p == 0) ? P0_BLOCKS : P1_BLOCKS;
            case (r.func)
                FN_ALLOC: begin
                    if (!ready[p]) clear_pool(p);
                    need = (r.size_bytes + BLK_BYTES - 1) / BLK_BYTES;
                    found = 0;
                    run = 0;
                    if (need != 0 && need <= blocks) begin
                        for (int b = blocks - 1; b >= 0 && !found; b--) begin
                            run = (rd(p, b) == 0) ? run + 1 : 0;
                            if (run == need) begin
                                for (int k = 0; k < need; k++) wr(p, b + k, 14'(need));
                                res.alloc_offset = 18'(b * BLK_BYTES);
                                found = 1;
                            end
                        end
                    end
                    if (!found) res.status = ST_FAIL;
                end
                FN_FREE: begin
                    if (!ready[p]) begin
                        clear_pool(p);
                        res.status = ST_NOT_READY;
                    end else if (r.offset_bytes >= blocks * BLK_BYTES) begin
                        res.status = ST_RANGE;
                    end else begin
                        idx = r.offset_bytes / BLK_BYTES;
                        stop = idx + rd(p, idx);
                        if (stop > blocks) stop = blocks;
                        for (int i = idx; i < stop; i++) wr(p, i, '0);
                    end
                end
                FN_USAGE: begin
                    used = 0;
                    for (int i = 0; i < blocks; i++) if (rd(p, i) != 0) used++;
                    res.usage_percent = 7'((used * 100) / blocks);
                end
                default: clear_pool(p);
            endcase
            pending.push_back(res);
        endfunction

        task check_result(t_res got);
            t_res exp_res;
            if (pending.size() == 0) begin
                report_mismatch("result with no request waiting");
                return;
            end
            exp_res = pending.pop_front();
            if (got.status !== exp_res.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, exp_res.status));
            if (got.alloc_offset !== exp_res.alloc_offset)
                report_mismatch($sformatf("alloc_offset %0d, want %0d",
                                          got.alloc_offset, exp_res.alloc_offset));
            if (got.usage_percent !== exp_res.usage_percent)
                report_mismatch($sformatf("usage %0d, want %0d",
                                          got.usage_percent, exp_res.usage_percent));
        endtask

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic i_cfg_wdata = 0;
    logic start = 0;
    t_req i_req = '0;
    logic busy, o_strobe;
    t_res o_res;

    alloc_scoreboard board;
    int idle_pct = 0;
    int quiet_cycles = 0;

    block_map_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .i_req(i_req), .busy(busy), .o_strobe(o_strobe), .o_res(o_res)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result(o_res);
        if (i_rst_n && ((start && !busy) || o_strobe)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("[block_map_allocator_top] ERROR");
            $finish;
        end
    end

    task automatic send_request(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        board.note_request(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_fallback(bit v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.ext_failed = v;
    endtask

    function automatic t_req make_req(logic [1:0] f, logic p, int sz, int off);
        t_req r;
        r.func = f;
        r.pool = p;
        r.size_bytes = 20'(sz);
        r.offset_bytes = 20'(off);
        return r;
    endfunction

    task automatic random_request();
        t_req r;
        int sel;
        sel = $urandom_range(99);
        r = '0;
        r.pool = 1'($urandom_range(1));
        if (sel < 50) begin
            r.func = FN_ALLOC;
            r.size_bytes = 20'(($urandom_range(9) == 0) ? $urandom : $urandom_range(700));
        end else if (sel < 80) begin
            r.func = FN_FREE;
            r.offset_bytes = 20'(($urandom_range(7) == 0) ? $urandom
                           : (P1_BLOCKS - 1 - $urandom_range(40)) * BLK_BYTES
                             + $urandom_range(31));
        end else if (sel < 95) begin
            r.func = FN_USAGE;
        end else begin
            r.func = FN_INIT;
        end
        if (r.func != FN_ALLOC && $urandom_range(1)) r.size_bytes = 20'($urandom);
        if (r.func != FN_FREE && $urandom_range(1)) r.offset_bytes = 20'($urandom);
        send_request(r);
    endtask

    initial begin
        board = new();
        board.reset_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        send_request(make_req(FN_FREE, 1'b0, 0, 0));
        send_request(make_req(FN_USAGE, 1'b1, 0, 0));
        send_request(make_req(FN_ALLOC, 1'b1, 0, 0));
        send_request(make_req(FN_ALLOC, 1'b1, 33, 0));
        send_request(make_req(FN_ALLOC, 1'b0, 1, 0));
        send_request(make_req(FN_ALLOC, 1'b0, 32, 0));
        send_request(make_req(FN_ALLOC, 1'b0, 20'hFFFFF, 0));
        send_request(make_req(FN_ALLOC, 1'b0, P0_BLOCKS * BLK_BYTES, 0));
        send_request(make_req(FN_USAGE, 1'b0, 0, 0));
        send_request(make_req(FN_ALLOC, 1'b0, 32, 0));
        send_request(make_req(FN_FREE, 1'b1, 0, 20'hFFFFF));
        send_request(make_req(FN_FREE, 1'b1, 0, P1_BLOCKS * BLK_BYTES));
        send_request(make_req(FN_FREE, 1'b1, 0, P1_BLOCKS * BLK_BYTES - 1));
        send_request(make_req(FN_FREE, 1'b1, 0, 0));
        send_request(make_req(FN_ALLOC, 1'b1, 100, 0));
        send_request(make_req(FN_INIT, 1'b0, 20'hFFFFF, 20'hFFFFF));
        send_request(make_req(FN_ALLOC, 1'b1, P1_BLOCKS * BLK_BYTES, 0));
        send_request(make_req(FN_USAGE, 1'b1, 0, 0));
        send_request(make_req(FN_ALLOC, 1'b1, 1, 0));
        send_request(make_req(FN_INIT, 1'b1, 0, 0));

        write_fallback(1'b1);
        send_request(make_req(FN_ALLOC, 1'b1, 64, 0));
        send_request(make_req(FN_USAGE, 1'b1, 0, 0));
        for (int i = 0; i < 120; i++) begin
            idle_pct = (i < 30) ? 0 : (i < 60) ? 48 : (i < 90) ? 21 : 48;
            if (i == 30) write_fallback(1'b0);
            if (i == 75) write_fallback(1'b1);
            if (i == 100) write_fallback(1'b0);
            random_request();
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[block_map_allocator_top] OK");
        else
            $display("[block_map_allocator_top] ERROR");
        $finish;
    end
endmodule

// ----- block_map_allocator_top.f -----
sv/bma_pkg.sv
sv/bma_ram.sv
sv/bma_div.sv
sv/block_map_allocator_top.sv
tb/block_map_allocator_top_tb.sv
